/* hw/rtl/kpc_pkg.sv */
package kpc_pkg;

    localparam int MAX_POINTS   = 4096;
    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_BITS   = 11;
    localparam int FRAC_BITS    = 8;
    localparam int QUERY_BITS   = 12;
    localparam int CL_W         = $clog2(MAX_CLUSTERS);
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
    localparam int CW           = COORD_BITS + FRAC_BITS;

    localparam logic [1:0] KIND_CENTER = 2'd0;
    localparam logic [1:0] KIND_LABEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic REG_CLUSTER_COUNT   = 1'b0;
    localparam logic REG_ITERATION_COUNT = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [10:0]           coord_x;
        logic [10:0]           coord_y;
        logic                  last_point;
        logic [11:0]           query_index;
    } kpc_req_t;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [2:0]            cluster_id;
        logic [18:0]           center_x;
        logic [18:0]           center_y;
        logic                  last_result;
    } kpc_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERR,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_PASS,
        ST_RD,
        ST_DIST,
        ST_CMP,
        ST_ACC,
        ST_UPD,
        ST_DIV,
        ST_EMIT,
        ST_QOUT
    } kpc_state_t;

    typedef struct packed {
        logic            pt_wr;
        logic            pt_rd;
        logic            q_rd;
        logic            sq_en;
        logic            sq_first;
        logic            clr_sums;
        logic            acc;
        logic            div_start;
        logic            seed_wr;
        logic            out_load;
        logic [1:0]      out_kind;
        logic            out_last;
        logic            q_hit;
        logic [CL_W-1:0] idx;
    } kpc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic div_done;
    } kpc_status_t;

endpackage

/* hw/rtl/kmeans_point_clustering_top.sv */
// channel   direction  beat                       handshake
// req       in         load point or label query  req_valid / req_stall
// rsp       out        center, label or error     rsp_valid / rsp_stall
// cfg       in         register index and value   cfg_valid / cfg_ready
//
// a load beat is taken at once and the last one starts a run; a label query is held
// until its result is loaded, which waits out any output stall; a run is paced by the
// sequential distance loop (one center per cycle) and the 32-step divider
// seeding happens on the first run only, then k center beats follow
// reset clears control state only; point and label memories need no clear
// req_stall is high while a run or query is in progress; rsp_stall holds the
// output register and the controller waits for it
module kmeans_point_clustering_top #(
    parameter int MAX_POINTS = kpc_pkg::MAX_POINTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  kpc_pkg::kpc_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output kpc_pkg::kpc_rsp_t rsp_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_data
);

    kpc_pkg::kpc_cmd_t             cmd;
    kpc_pkg::kpc_status_t          status;
    logic [$clog2(MAX_POINTS)-1:0] pt_idx;

    assign cfg_ready = 1'b1;

    kpc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .pt_idx    (pt_idx)
    );

    kpc_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pt_idx    (pt_idx),
        .req_data  (req_data),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

/* hw/rtl/kpc_ram.sv */
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/kpc_div.sv */
module kpc_div #(
    parameter int DW = 32,
    parameter int VW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dvd_x,
    input  logic [DW-1:0] dvd_y,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quo_x,
    output logic [DW-1:0] quo_y
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    dq_x_reg, dq_x_next;
    logic [DW-1:0]    dq_y_reg, dq_y_next;
    logic [VW-1:0]    rem_x_reg, rem_x_next;
    logic [VW-1:0]    rem_y_reg, rem_y_next;
    logic [VW-1:0]    dv_reg, dv_next;
    logic [VW:0]      tx, ty;

    // one restoring step per cycle on both lanes
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dq_x_next  = dq_x_reg;
        dq_y_next  = dq_y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        dv_next    = dv_reg;
        tx         = {rem_x_reg, dq_x_reg[DW-1]};
        ty         = {rem_y_reg, dq_y_reg[DW-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(DW);
            dq_x_next  = dvd_x;
            dq_y_next  = dvd_y;
            rem_x_next = '0;
            rem_y_next = '0;
            dv_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (tx >= {1'b0, dv_reg})
            begin
                rem_x_next = VW'(tx - {1'b0, dv_reg});
                dq_x_next  = {dq_x_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_x_next = tx[VW-1:0];
                dq_x_next  = {dq_x_reg[DW-2:0], 1'b0};
            end
            if (ty >= {1'b0, dv_reg})
            begin
                rem_y_next = VW'(ty - {1'b0, dv_reg});
                dq_y_next  = {dq_y_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_y_next = ty[VW-1:0];
                dq_y_next  = {dq_y_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_x_reg  <= dq_x_next;
        dq_y_reg  <= dq_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        dv_reg    <= dv_next;
    end

    assign done  = done_reg;
    assign quo_x = dq_x_reg;
    assign quo_y = dq_y_reg;

endmodule

/* hw/rtl/kpc_datapath.sv */
module kpc_datapath #(
    parameter int MAX_POINTS = kpc_pkg::MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kpc_pkg::kpc_cmd_t             cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] pt_idx,
    input  kpc_pkg::kpc_req_t             req_data,
    output kpc_pkg::kpc_status_t          status,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output kpc_pkg::kpc_rsp_t             rsp_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PT_W  = $clog2(MAX_POINTS + 1);
    localparam int QW    = (kpc_pkg::QUERY_BITS > PT_W) ? kpc_pkg::QUERY_BITS : PT_W;
    localparam int CB    = kpc_pkg::COORD_BITS;
    localparam int CW    = kpc_pkg::CW;
    localparam int SQ_W  = 2 * CW;
    localparam int SW    = CB + PT_W;
    localparam int DW    = SW + kpc_pkg::FRAC_BITS;
    localparam int NC    = kpc_pkg::MAX_CLUSTERS;
    localparam int CL_W  = kpc_pkg::CL_W;

    logic [2*CB-1:0]  pt_rdata;
    logic [CL_W-1:0]  lab_rdata;
    logic [QW-1:0]    q_ext;

    logic [CW-1:0]    cen_x_reg [NC];
    logic [CW-1:0]    cen_y_reg [NC];
    logic [SW-1:0]    sum_x_reg [NC];
    logic [SW-1:0]    sum_y_reg [NC];
    logic [PT_W-1:0]  cnt_reg   [NC];

    logic [CW-1:0]    px, py, cx, cy, dx, dy;
    logic [SQ_W-1:0]  sq_x_reg, sq_y_reg;
    logic             sq_vld_reg, sq_first_reg;
    logic [CL_W-1:0]  sq_j_reg;
    logic [SQ_W:0]    sq_sum;
    logic [SQ_W:0]    best_d_reg;
    logic [CL_W-1:0]  best_reg;

    logic             div_done;
    logic [DW-1:0]    quo_x, quo_y;

    logic             rsp_valid_reg;
    kpc_pkg::kpc_rsp_t rsp_data_reg;

    assign q_ext = QW'(req_data.query_index);

    kpc_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk   (clk),
        .we    (cmd.pt_wr),
        .waddr (pt_idx),
        .wdata ({req_data.coord_x, req_data.coord_y}),
        .re    (cmd.pt_rd),
        .raddr (pt_idx),
        .rdata (pt_rdata)
    );

    kpc_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_label_ram (
        .clk   (clk),
        .we    (cmd.acc),
        .waddr (pt_idx),
        .wdata (best_reg),
        .re    (cmd.q_rd),
        .raddr (q_ext[AW-1:0]),
        .rdata (lab_rdata)
    );

    kpc_div #(.DW(DW), .VW(PT_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dvd_x   (DW'(sum_x_reg[cmd.idx]) << kpc_pkg::FRAC_BITS),
        .dvd_y   (DW'(sum_y_reg[cmd.idx]) << kpc_pkg::FRAC_BITS),
        .divisor (cnt_reg[cmd.idx]),
        .done    (div_done),
        .quo_x   (quo_x),
        .quo_y   (quo_y)
    );

    assign px     = CW'(pt_rdata[2*CB-1:CB]) << kpc_pkg::FRAC_BITS;
    assign py     = CW'(pt_rdata[CB-1:0]) << kpc_pkg::FRAC_BITS;
    assign cx     = cen_x_reg[cmd.idx];
    assign cy     = cen_y_reg[cmd.idx];
    assign dx     = (px > cx) ? px - cx : cx - px;
    assign dy     = (py > cy) ? py - cy : cy - py;
    assign sq_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    // squares registered, compare in the following cycle
    always_ff @(posedge clk)
    begin
        sq_x_reg     <= SQ_W'(dx) * SQ_W'(dx);
        sq_y_reg     <= SQ_W'(dy) * SQ_W'(dy);
        sq_first_reg <= cmd.sq_first;
        sq_j_reg     <= cmd.idx;
        if (sq_vld_reg && (sq_first_reg || sq_sum < best_d_reg))
        begin
            best_d_reg <= sq_sum;
            best_reg   <= sq_j_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= cmd.sq_en;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (cmd.clr_sums)
            begin
                sum_x_reg[c] <= '0;
                sum_y_reg[c] <= '0;
                cnt_reg[c]   <= '0;
            end
            else if (cmd.acc && best_reg == CL_W'(c))
            begin
                sum_x_reg[c] <= sum_x_reg[c] + SW'(pt_rdata[2*CB-1:CB]);
                sum_y_reg[c] <= sum_y_reg[c] + SW'(pt_rdata[CB-1:0]);
                cnt_reg[c]   <= cnt_reg[c] + 1'b1;
            end
        end
        if (cmd.seed_wr)
        begin
            cen_x_reg[cmd.idx] <= px;
            cen_y_reg[cmd.idx] <= py;
        end
        else if (div_done)
        begin
            cen_x_reg[cmd.idx] <= quo_x[CW-1:0];
            cen_y_reg[cmd.idx] <= quo_y[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_data_reg.result_kind <= cmd.out_kind;
            rsp_data_reg.last_result <= cmd.out_last;
            rsp_data_reg.cluster_id  <= '0;
            rsp_data_reg.center_x    <= '0;
            rsp_data_reg.center_y    <= '0;
            case (cmd.out_kind)
                kpc_pkg::KIND_CENTER:
                begin
                    rsp_data_reg.cluster_id <= 3'(cmd.idx);
                    rsp_data_reg.center_x   <= 19'(cx);
                    rsp_data_reg.center_y   <= 19'(cy);
                end
                kpc_pkg::KIND_LABEL:
                begin
                    rsp_data_reg.cluster_id <= cmd.q_hit ? 3'(lab_rdata) : 3'd0;
                end
                default:
                begin
                    rsp_data_reg.cluster_id <= 3'd0;
                end
            endcase
        end
    end

    assign status.out_free   = !rsp_valid_reg || !rsp_stall;
    assign status.count_zero = (cnt_reg[cmd.idx] == '0);
    assign status.div_done   = div_done;
    assign rsp_valid         = rsp_valid_reg;
    assign rsp_data          = rsp_data_reg;

endmodule

/* hw/rtl/kpc_ctrl.sv */
module kpc_ctrl #(
    parameter int MAX_POINTS = kpc_pkg::MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  kpc_pkg::kpc_req_t             req_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [3:0]                    cfg_data,
    input  kpc_pkg::kpc_status_t          status,
    output kpc_pkg::kpc_cmd_t             cmd,
    output logic [$clog2(MAX_POINTS)-1:0] pt_idx
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PT_W  = $clog2(MAX_POINTS + 1);
    localparam int QW    = (kpc_pkg::QUERY_BITS > PT_W) ? kpc_pkg::QUERY_BITS : PT_W;
    localparam int CNT_W = kpc_pkg::CNT_W;
    localparam int CL_W  = kpc_pkg::CL_W;

    kpc_pkg::kpc_state_t state_reg, state_next;
    logic [PT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [3:0]       it_reg, it_next;
    logic [PT_W-1:0]  loaded_reg, loaded_next;
    logic [PT_W-1:0]  n_reg, n_next;
    logic [PT_W-1:0]  labeled_reg, labeled_next;
    logic             seeded_reg, seeded_next;
    logic             hit_reg, hit_next;
    logic [3:0]       cc_reg, ic_reg;
    logic [CNT_W-1:0] k_eff;
    logic [3:0]       it_eff;
    logic             accept;
    logic             room;
    logic [PT_W-1:0]  loaded_inc;

    assign k_eff  = (cc_reg == 4'd0) ? CNT_W'(1) :
                    (cc_reg > 4'(kpc_pkg::MAX_CLUSTERS)) ? CNT_W'(kpc_pkg::MAX_CLUSTERS) :
                    CNT_W'(cc_reg);
    assign it_eff = (ic_reg == 4'd0) ? 4'd1 : ic_reg;
    assign accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != kpc_pkg::ST_IDLE);
    assign room       = (loaded_reg < PT_W'(MAX_POINTS));
    assign loaded_inc = room ? loaded_reg + 1'b1 : loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= 4'd5;
            ic_reg <= 4'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kpc_pkg::REG_CLUSTER_COUNT:   cc_reg <= cfg_data;
                kpc_pkg::REG_ITERATION_COUNT: ic_reg <= cfg_data;
                default:                      cc_reg <= cc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kpc_pkg::ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            it_reg      <= '0;
            loaded_reg  <= '0;
            n_reg       <= '0;
            labeled_reg <= '0;
            seeded_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            it_reg      <= it_next;
            loaded_reg  <= loaded_next;
            n_reg       <= n_next;
            labeled_reg <= labeled_next;
            seeded_reg  <= seeded_next;
            hit_reg     <= hit_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        it_next      = it_reg;
        loaded_next  = loaded_reg;
        n_next       = n_reg;
        labeled_next = labeled_reg;
        seeded_next  = seeded_reg;
        hit_next     = hit_reg;
        cmd          = '0;
        cmd.idx      = j_reg[CL_W-1:0];
        cmd.q_hit    = hit_reg;
        pt_idx       = i_reg[AW-1:0];

        unique case (state_reg)
            kpc_pkg::ST_IDLE:
            begin
                pt_idx = loaded_reg[AW-1:0];
                if (accept)
                begin
                    if (req_data.req_type == kpc_pkg::REQ_QUERY)
                    begin
                        cmd.q_rd   = 1'b1;
                        hit_next   = QW'(req_data.query_index) < QW'(labeled_reg);
                        state_next = kpc_pkg::ST_QOUT;
                    end
                    else
                    begin
                        cmd.pt_wr   = room;
                        loaded_next = loaded_inc;
                        if (req_data.last_point)
                        begin
                            n_next      = loaded_inc;
                            loaded_next = '0;
                            state_next  = kpc_pkg::ST_CHECK;
                        end
                    end
                end
            end
            kpc_pkg::ST_CHECK:
            begin
                j_next = '0;
                if (n_reg < PT_W'(k_eff))
                begin
                    state_next = kpc_pkg::ST_ERR;
                end
                else if (!seeded_reg)
                begin
                    state_next = kpc_pkg::ST_SEED_RD;
                end
                else
                begin
                    it_next    = '0;
                    state_next = kpc_pkg::ST_PASS;
                end
            end
            kpc_pkg::ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kpc_pkg::KIND_ERROR;
                    cmd.out_last = 1'b1;
                    state_next   = kpc_pkg::ST_IDLE;
                end
            end
            kpc_pkg::ST_SEED_RD:
            begin
                pt_idx     = AW'(j_reg);
                cmd.pt_rd  = 1'b1;
                state_next = kpc_pkg::ST_SEED_WR;
            end
            kpc_pkg::ST_SEED_WR:
            begin
                cmd.seed_wr = 1'b1;
                j_next      = j_reg + 1'b1;
                if (j_reg + 1'b1 == k_eff)
                begin
                    seeded_next = 1'b1;
                    it_next     = '0;
                    state_next  = kpc_pkg::ST_PASS;
                end
                else
                begin
                    state_next = kpc_pkg::ST_SEED_RD;
                end
            end
            kpc_pkg::ST_PASS:
            begin
                cmd.clr_sums = 1'b1;
                i_next       = '0;
                state_next   = kpc_pkg::ST_RD;
            end
            kpc_pkg::ST_RD:
            begin
                cmd.pt_rd  = 1'b1;
                j_next     = '0;
                state_next = kpc_pkg::ST_DIST;
            end
            kpc_pkg::ST_DIST:
            begin
                cmd.sq_en    = 1'b1;
                cmd.sq_first = (j_reg == '0);
                if (j_reg + 1'b1 == k_eff)
                begin
                    state_next = kpc_pkg::ST_CMP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            kpc_pkg::ST_CMP:
            begin
                state_next = kpc_pkg::ST_ACC;
            end
            kpc_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                i_next  = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                begin
                    j_next     = '0;
                    state_next = kpc_pkg::ST_UPD;
                end
                else
                begin
                    state_next = kpc_pkg::ST_RD;
                end
            end
            kpc_pkg::ST_UPD:
            begin
                if (j_reg == k_eff)
                begin
                    it_next = it_reg + 1'b1;
                    j_next  = '0;
                    if (it_reg + 1'b1 == it_eff)
                    begin
                        labeled_next = n_reg;
                        state_next   = kpc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = kpc_pkg::ST_PASS;
                    end
                end
                else if (status.count_zero)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = kpc_pkg::ST_DIV;
                end
            end
            kpc_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = kpc_pkg::ST_UPD;
                end
            end
            kpc_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kpc_pkg::KIND_CENTER;
                    cmd.out_last = (j_reg + 1'b1 == k_eff);
                    j_next       = j_reg + 1'b1;
                    if (j_reg + 1'b1 == k_eff)
                    begin
                        state_next = kpc_pkg::ST_IDLE;
                    end
                end
            end
            kpc_pkg::ST_QOUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kpc_pkg::KIND_LABEL;
                    cmd.out_last = 1'b1;
                    state_next   = kpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/kpc_checker.sv */
module kpc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input kpc_pkg::kpc_req_t req_data,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input kpc_pkg::kpc_rsp_t rsp_data
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    // label results carry no center
    a_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind == kpc_pkg::KIND_LABEL |->
        rsp_data.center_x == '0 && rsp_data.center_y == '0 && rsp_data.last_result)
        else $error("label result malformed");

    // error result is single and empty
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind == kpc_pkg::KIND_ERROR |->
        rsp_data.last_result && rsp_data.cluster_id == 3'd0)
        else $error("error result malformed");

    // a query keeps the input stalled next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.req_type == kpc_pkg::REQ_QUERY |=> req_stall)
        else $error("query did not stall input");

endmodule

bind kmeans_point_clustering_top kpc_checker u_kpc_checker (.*);

/* verif/kmeans_point_clustering_top_tb.sv */
`timescale 1ns / 1ps

module kmeans_point_clustering_top_tb;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 420;
    localparam int MAX_POINTS   = kpc_pkg::MAX_POINTS;
    localparam int MAX_CLUSTERS = kpc_pkg::MAX_CLUSTERS;
    localparam int FRAC_BITS    = kpc_pkg::FRAC_BITS;

    typedef struct {
        bit                cfg_wr;
        logic              cfg_idx;
        logic [3:0]        cfg_val;
        kpc_pkg::kpc_req_t req;
        bit                typed;
        kpc_pkg::kpc_rsp_t rsp;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    kpc_pkg::kpc_req_t req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    kpc_pkg::kpc_rsp_t rsp_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [3:0]        cfg_data;

    // predictor state
    logic [3:0]      cluster_reg;
    logic [3:0]      iter_reg;
    logic [10:0]     pt_x [MAX_POINTS];
    logic [10:0]     pt_y [MAX_POINTS];
    logic [2:0]      pt_label [MAX_POINTS];
    longint unsigned ctr_x [MAX_CLUSTERS];
    longint unsigned ctr_y [MAX_CLUSTERS];
    bit              seeded;
    int unsigned     n_loaded;
    int unsigned     n_labeled;

    kpc_pkg::kpc_rsp_t pending_rsp [$];

    int unsigned cycles;
    int unsigned errors;
    int unsigned items_in;
    int unsigned beats_out;
    int unsigned runs_done;
    int unsigned error_beats;
    bit          no_idle;
    bit          long_hold;

    kmeans_point_clustering_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        cycles = 0;
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_rsp.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic kpc_pkg::kpc_rsp_t make_rsp(logic [1:0] kind, logic [2:0] id,
                                                   longint unsigned cx, longint unsigned cy,
                                                   logic last);
        kpc_pkg::kpc_rsp_t r;
        r.result_kind = kind;
        r.cluster_id  = id;
        r.center_x    = cx[18:0];
        r.center_y    = cy[18:0];
        r.last_result = last;
        return r;
    endfunction

    function automatic void lloyd_pass(int unsigned n, int unsigned k);
        longint unsigned sx [MAX_CLUSTERS];
        longint unsigned sy [MAX_CLUSTERS];
        int unsigned     cnt [MAX_CLUSTERS];
        longint unsigned px, py, dx, dy, d, best_d;
        int unsigned     best;
        for (int j = 0; j < MAX_CLUSTERS; j++)
        begin
            sx[j] = 0;
            sy[j] = 0;
            cnt[j] = 0;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            px = longint'(pt_x[i]) << FRAC_BITS;
            py = longint'(pt_y[i]) << FRAC_BITS;
            best_d = 0;
            best = 0;
            for (int unsigned j = 0; j < k; j++)
            begin
                dx = px > ctr_x[j] ? px - ctr_x[j] : ctr_x[j] - px;
                dy = py > ctr_y[j] ? py - ctr_y[j] : ctr_y[j] - py;
                d = dx * dx + dy * dy;
                if (j == 0 || d < best_d)
                begin
                    best_d = d;
                    best = j;
                end
            end
            pt_label[i] = best[2:0];
            cnt[best]++;
            sx[best] += pt_x[i];
            sy[best] += pt_y[i];
        end
        for (int unsigned j = 0; j < k; j++)
        begin
            if (cnt[j] != 0)
            begin
                ctr_x[j] = (sx[j] << FRAC_BITS) / cnt[j];
                ctr_y[j] = (sy[j] << FRAC_BITS) / cnt[j];
            end
        end
    endfunction

    function automatic void cluster_predict(kpc_pkg::kpc_req_t r);
        int unsigned k, iters, n;
        if (r.req_type == kpc_pkg::REQ_QUERY)
        begin
            pending_rsp.push_back(make_rsp(kpc_pkg::KIND_LABEL,
                r.query_index < n_labeled ? pt_label[r.query_index] : 3'd0, 0, 0, 1'b1));
            return;
        end
        if (n_loaded < MAX_POINTS)
        begin
            pt_x[n_loaded] = r.coord_x;
            pt_y[n_loaded] = r.coord_y;
            n_loaded++;
        end
        if (!r.last_point)
            return;
        k = cluster_reg == 0 ? 1 : (cluster_reg > MAX_CLUSTERS ? MAX_CLUSTERS : cluster_reg);
        iters = iter_reg == 0 ? 1 : iter_reg;
        n = n_loaded;
        n_loaded = 0;
        if (n < k)
        begin
            pending_rsp.push_back(make_rsp(kpc_pkg::KIND_ERROR, 3'd0, 0, 0, 1'b1));
            return;
        end
        if (!seeded)
        begin
            for (int unsigned j = 0; j < k; j++)
            begin
                ctr_x[j] = longint'(pt_x[j]) << FRAC_BITS;
                ctr_y[j] = longint'(pt_y[j]) << FRAC_BITS;
            end
            seeded = 1'b1;
        end
        for (int unsigned it = 0; it < iters; it++)
            lloyd_pass(n, k);
        n_labeled = n;
        runs_done++;
        for (int unsigned j = 0; j < k; j++)
            pending_rsp.push_back(make_rsp(kpc_pkg::KIND_CENTER, j[2:0], ctr_x[j], ctr_y[j],
                                           j + 1 == k));
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // receiver: random stall per beat, one long hold-off on request
    initial
    begin
        int unsigned       hold;
        kpc_pkg::kpc_rsp_t want;
        hold = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                beats_out++;
                if (pending_rsp.size() == 0)
                begin
                    $display("unexpected beat kind %0d id %0d at cycle %0d",
                             rsp_data.result_kind, rsp_data.cluster_id, cycles);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_data.result_kind !== want.result_kind)
                        report("result_kind", rsp_data.result_kind, want.result_kind);
                    if (rsp_data.cluster_id !== want.cluster_id)
                        report("cluster_id", rsp_data.cluster_id, want.cluster_id);
                    if (rsp_data.center_x !== want.center_x)
                        report("center_x", rsp_data.center_x, want.center_x);
                    if (rsp_data.center_y !== want.center_y)
                        report("center_y", rsp_data.center_y, want.center_y);
                    if (rsp_data.last_result !== want.last_result)
                        report("last_result", rsp_data.last_result, want.last_result);
                    if (want.result_kind == kpc_pkg::KIND_ERROR)
                        error_beats++;
                end
                hold = draw_gap();
            end
            else if (hold > 0)
                hold--;
            if (long_hold)
            begin
                hold = 300;
                long_hold = 1'b0;
            end
            rsp_stall <= (hold > 0);
        end
    end

    task automatic send_req(kpc_pkg::kpc_req_t r);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        cluster_predict(r);
        items_in++;
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kpc_pkg::REG_CLUSTER_COUNT)
            cluster_reg = val;
        else
            iter_reg = val;
    endtask

    function automatic kpc_pkg::kpc_req_t load_req(int x, int y, bit last);
        kpc_pkg::kpc_req_t r;
        r.req_type    = kpc_pkg::REQ_LOAD;
        r.coord_x     = x[10:0];
        r.coord_y     = y[10:0];
        r.last_point  = last;
        r.query_index = $urandom_range(0, 4095);
        return r;
    endfunction

    function automatic kpc_pkg::kpc_req_t query_req(int idx);
        kpc_pkg::kpc_req_t r;
        r.req_type    = kpc_pkg::REQ_QUERY;
        r.coord_x     = $urandom_range(0, 2047);
        r.coord_y     = $urandom_range(0, 2047);
        r.last_point  = $urandom_range(0, 1);
        r.query_index = idx[11:0];
        return r;
    endfunction

    function automatic stim_row_t row_req(kpc_pkg::kpc_req_t r);
        stim_row_t s;
        s.cfg_wr  = 1'b0;
        s.cfg_idx = kpc_pkg::REG_CLUSTER_COUNT;
        s.cfg_val = 4'd0;
        s.req     = r;
        s.typed   = 1'b0;
        s.rsp     = '0;
        return s;
    endfunction

    function automatic stim_row_t row_typed(kpc_pkg::kpc_req_t r, kpc_pkg::kpc_rsp_t e);
        stim_row_t s;
        s = row_req(r);
        s.typed = 1'b1;
        s.rsp   = e;
        return s;
    endfunction

    function automatic stim_row_t row_cfg(logic idx, logic [3:0] val);
        stim_row_t s;
        s = row_req('0);
        s.cfg_wr  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        return s;
    endfunction

    initial
    begin
        stim_row_t         plan [$];
        int unsigned       n, k, base_x, base_y, mode, phase, start_items;
        kpc_pkg::kpc_rsp_t dropped;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= kpc_pkg::REG_CLUSTER_COUNT;
        cfg_data  <= 4'd0;
        errors = 0;
        items_in = 0;
        beats_out = 0;
        runs_done = 0;
        error_beats = 0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        cluster_reg = 4'd5;
        iter_reg = 4'd5;
        seeded = 1'b0;
        n_loaded = 0;
        n_labeled = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        plan.push_back(row_typed(query_req(0),
                                 make_rsp(kpc_pkg::KIND_LABEL, 0, 0, 0, 1)));
        plan.push_back(row_req(load_req(0, 0, 0)));
        plan.push_back(row_req(load_req(2047, 2047, 0)));
        plan.push_back(row_typed(load_req(5, 5, 1),
                                 make_rsp(kpc_pkg::KIND_ERROR, 0, 0, 0, 1)));
        plan.push_back(row_cfg(kpc_pkg::REG_CLUSTER_COUNT, 4'd8));
        plan.push_back(row_cfg(kpc_pkg::REG_ITERATION_COUNT, 4'd15));
        plan.push_back(row_req(load_req(0, 0, 0)));
        plan.push_back(row_req(load_req(2047, 2047, 0)));
        plan.push_back(row_req(load_req(2047, 0, 0)));
        plan.push_back(row_req(load_req(0, 2047, 0)));
        plan.push_back(row_req(load_req(1024, 1024, 0)));
        plan.push_back(row_req(load_req(100, 100, 0)));
        plan.push_back(row_req(load_req(102, 100, 0)));
        plan.push_back(row_req(load_req(1500, 300, 0)));
        // equidistant from two seeds: lower index wins
        plan.push_back(row_req(load_req(101, 100, 0)));
        plan.push_back(row_req(load_req(1023, 1023, 1)));
        plan.push_back(row_req(query_req(0)));
        plan.push_back(row_req(query_req(8)));
        plan.push_back(row_req(query_req(9)));
        plan.push_back(row_typed(query_req(10),
                                 make_rsp(kpc_pkg::KIND_LABEL, 0, 0, 0, 1)));
        plan.push_back(row_typed(query_req(4095),
                                 make_rsp(kpc_pkg::KIND_LABEL, 0, 0, 0, 1)));
        foreach (plan[i])
        begin
            if (plan[i].cfg_wr)
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            else
            begin
                send_req(plan[i].req);
                if (plan[i].typed)
                begin
                    dropped = pending_rsp.pop_back();
                    if (dropped !== plan[i].rsp)
                        report("typed row", dropped, plan[i].rsp);
                    pending_rsp.push_back(plan[i].rsp);
                end
            end
        end

        // back-pressure: receiver holds off while queries keep coming
        no_idle = 1'b1;
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++)
            send_req(query_req($urandom_range(0, 11)));
        no_idle = 1'b0;

        // random part
        start_items = items_in;
        phase = 0;
        while (items_in - start_items < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    write_reg(kpc_pkg::REG_CLUSTER_COUNT, 4'd0);
                    write_reg(kpc_pkg::REG_ITERATION_COUNT, 4'd0);
                end
                1:
                begin
                    write_reg(kpc_pkg::REG_CLUSTER_COUNT, 4'd15);
                    write_reg(kpc_pkg::REG_ITERATION_COUNT, 4'd15);
                end
                2:
                begin
                    write_reg(kpc_pkg::REG_CLUSTER_COUNT, 4'd1);
                    write_reg(kpc_pkg::REG_ITERATION_COUNT, 4'd1);
                end
                3:
                begin
                    write_reg(kpc_pkg::REG_CLUSTER_COUNT, 4'd8);
                    write_reg(kpc_pkg::REG_ITERATION_COUNT, 4'd15);
                end
                default:
                begin
                    write_reg(kpc_pkg::REG_CLUSTER_COUNT, $urandom_range(0, 15));
                    write_reg(kpc_pkg::REG_ITERATION_COUNT, $urandom_range(0, 15));
                end
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            k = cluster_reg == 0 ? 1 : (cluster_reg > MAX_CLUSTERS ? MAX_CLUSTERS : cluster_reg);
            if (k > 1 && $urandom_range(0, 7) == 0)
                n = $urandom_range(1, k - 1);
            else
                n = $urandom_range(k, 40);
            mode = $urandom_range(0, 2);
            base_x = $urandom_range(0, 2047);
            base_y = $urandom_range(0, 2047);
            for (int unsigned i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_req(query_req($urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                            : $urandom_range(0, 40)));
                if (mode == 0)
                    send_req(load_req($urandom_range(0, 3), $urandom_range(0, 3), i + 1 == n));
                else if (mode == 1)
                    send_req(load_req((base_x + $urandom_range(0, 60)) % 2048,
                                      (base_y + $urandom_range(0, 60)) % 2048, i + 1 == n));
                else
                    send_req(load_req($urandom_range(0, 2047), $urandom_range(0, 2047),
                                      i + 1 == n));
            end
            for (int i = $urandom_range(0, 4); i > 0; i--)
                send_req(query_req($urandom_range(0, 3) != 0 ? $urandom_range(0, n)
                                                            : $urandom_range(0, 4095)));
            phase++;
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("%0d results never arrived", pending_rsp.size());
            errors++;
        end
        $display("covered %0d request beats, %0d result beats, %0d clustering runs",
                 items_in, beats_out, runs_done);
        $display("too-few-point errors %0d, long output hold-off included, %0d mismatches",
                 error_beats, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
